// File: hdl/feacc_pkg.sv
// ----------------------------------------------------------------------------
// feacc_pkg
// shared constants, codes and helpers for the forecast error metric block
// ----------------------------------------------------------------------------
package feacc_pkg;

   localparam int IN_W       = 32;
   localparam int SUM_W      = 64;
   localparam int SCORE_W    = 48;
   localparam int MODE_W     = 3;
   // widest per-request dividend: twice an absolute error
   localparam int ITEM_NUM_W = 33;

   localparam logic [SUM_W-1:0] RATIO_MAX     = 64'h0000_0000_FFFF_FFFF;
   localparam logic [SUM_W-1:0] SCORE_MAG_MAX = 64'h0000_8000_0000_0000;

   localparam logic [MODE_W-1:0] MODE_MAXAE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_MAE   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MASE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MSE   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_RMSE  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_RMSPE = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SMAPE = 3'd6;
   // spare code: adds nothing and scores zero
   localparam logic [MODE_W-1:0] MODE_NONE  = 3'd7;

   typedef enum logic [2:0] {
      TAG_RATIO,
      TAG_SMAPE,
      TAG_MEAN,
      TAG_SCALE,
      TAG_MASE
   } div_tag_type;

   // saturating add, carry flag in the top bit
   function automatic logic [SUM_W:0] sat_add(input logic [SUM_W-1:0] a,
                                              input logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[SUM_W]) begin
         s = {1'b1, {SUM_W{1'b1}}};
      end
      return s;
   endfunction

endpackage

// File: hdl/forecast_error_metric_accumulator.sv
// ----------------------------------------------------------------------------
// forecast_error_metric_accumulator
// running error statistics over a series, one negated metric per final request
// ----------------------------------------------------------------------------
// requests are taken one at a time: req_ready is high only in the idle state; in
//   mode 5 (with a nonzero actual) and mode 6 each request also passes through
//   the shared bit-serial divide/square-root unit
// a final request runs the rest of its metric before its response
//   (one or three divider passes, or one divider pass and 32 square-root steps)
// synchronous active-high reset clears the series state, mode and output valid
module forecast_error_metric_accumulator #(
   parameter int MAX_ITEMS = 65536,
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [feacc_pkg::IN_W-1:0]    req_predicted,
   input  logic signed [feacc_pkg::IN_W-1:0]    req_observed,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [feacc_pkg::SCORE_W-1:0] rsp_score,
   output logic                                 rsp_saturated,
   input  logic                                 csr_wr_en,
   input  logic [feacc_pkg::MODE_W-1:0]         csr_wr_data
);

   localparam int DW = feacc_pkg::SUM_W + FRAC_BITS;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int KW = $clog2(DW + 1);
   localparam logic [KW-1:0] DIV_STEPS  = KW'(DW);
   localparam logic [KW-1:0] ITEM_STEPS = KW'(feacc_pkg::ITEM_NUM_W + FRAC_BITS);
   localparam logic [KW-1:0] SQRT_STEPS = KW'(32);
   localparam logic [CW-1:0] CNT_MAX    = CW'(MAX_ITEMS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_UPD,
      S_MUL,
      S_ACC,
      S_CHK,
      S_DIV,
      S_DDONE,
      S_SQRT,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic signed [31:0] pred_ff, pred_in, obs_ff, obs_in, prev_obs_ff, prev_obs_in;
   logic               last_ff, last_in;
   logic [2:0]         mode_ff, mode_in;
   logic [63:0]        err_sum_ff, err_sum_in, naive_sum_ff, naive_sum_in;
   logic [31:0]        max_err_ff, max_err_in;
   logic [CW-1:0]      item_cnt_ff, item_cnt_in, used_cnt_ff, used_cnt_in;
   logic               ovf_ff, ovf_in;
   logic [63:0]        acc_ff, acc_in;
   logic [31:0]        mul_ff, mul_in;
   logic [63:0]        rem_ff, rem_in;
   logic [DW-1:0]      qd_ff, qd_in;
   logic [63:0]        den_ff, den_in;
   logic [63:0]        sq_bit_ff, sq_bit_in;
   logic [KW-1:0]      step_ff, step_in;
   feacc_pkg::div_tag_type tag_ff, tag_in;
   logic [63:0]        scale_ff, scale_in;
   logic [63:0]        mag_ff, mag_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [47:0]        score_ff, score_in;
   logic               sat_ff, sat_in;

   // per-request arithmetic
   logic signed [32:0] d_pa, d_ap;
   logic [32:0]        d_pa_mag, d_ap_mag, p_mag, a_mag, s_sum;
   logic [31:0]        ad;
   logic [64:0]        naive_add, err_add;
   logic [63:0]        prod;

   // shared subtractor of the divide / square-root unit
   logic [64:0]        sub_a, sub_b;
   logic [65:0]        sub_diff;
   logic               sub_ok;
   logic [63:0]        q_cl, q_lim;
   logic               q_over;
   logic [DW-1:0]      sq_res_next;

   // divider launch
   logic               div_start, div_item, div_frac;
   logic [63:0]        div_num, div_den;
   feacc_pkg::div_tag_type div_tag;

   assign d_pa     = {pred_ff[31], pred_ff} - {obs_ff[31], obs_ff};
   assign d_ap     = {obs_ff[31], obs_ff} - {prev_obs_ff[31], prev_obs_ff};
   assign d_pa_mag = d_pa[32] ? 33'(-d_pa) : d_pa;
   assign d_ap_mag = d_ap[32] ? 33'(-d_ap) : d_ap;
   assign p_mag    = pred_ff[31] ? 33'(-{pred_ff[31], pred_ff}) : {1'b0, pred_ff};
   assign a_mag    = obs_ff[31] ? 33'(-{obs_ff[31], obs_ff}) : {1'b0, obs_ff};
   assign ad       = d_pa_mag[31:0];
   assign s_sum    = p_mag + a_mag;
   assign naive_add = feacc_pkg::sat_add(naive_sum_ff, {32'b0, d_ap_mag[31:0]});
   assign err_add   = feacc_pkg::sat_add(err_sum_ff, acc_ff);
   assign prod      = mul_ff * mul_ff;

   always_comb begin
      if (state_ff == S_SQRT) begin
         // x against res + bit; rem holds x, low quotient bits hold res
         sub_a = {1'b0, rem_ff};
         sub_b = {1'b0, qd_ff[63:0] + sq_bit_ff};
      end else begin
         sub_a = {rem_ff, qd_ff[DW-1]};
         sub_b = {1'b0, den_ff};
      end
   end
   assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ok   = !sub_diff[65];
   assign sq_res_next = sub_ok ? DW'((qd_ff[63:0] >> 1) + sq_bit_ff)
                               : DW'(qd_ff[63:0] >> 1);

   always_comb begin
      case (tag_ff)
         feacc_pkg::TAG_RATIO: q_lim = feacc_pkg::RATIO_MAX;
         feacc_pkg::TAG_SMAPE,
         feacc_pkg::TAG_MASE:  q_lim = feacc_pkg::SCORE_MAG_MAX;
         default:              q_lim = {64{1'b1}};
      endcase
   end
   assign q_over = qd_ff > DW'(q_lim);
   assign q_cl   = q_over ? q_lim : qd_ff[63:0];

   always_comb begin
      state_in     = state_ff;
      pred_in      = pred_ff;
      obs_in       = obs_ff;
      last_in      = last_ff;
      mode_in      = csr_wr_en ? csr_wr_data : mode_ff;
      err_sum_in   = err_sum_ff;
      naive_sum_in = naive_sum_ff;
      max_err_in   = max_err_ff;
      item_cnt_in  = item_cnt_ff;
      used_cnt_in  = used_cnt_ff;
      prev_obs_in  = prev_obs_ff;
      ovf_in       = ovf_ff;
      acc_in       = acc_ff;
      mul_in       = mul_ff;
      rem_in       = rem_ff;
      qd_in        = qd_ff;
      den_in       = den_ff;
      sq_bit_in    = sq_bit_ff;
      step_in      = step_ff;
      tag_in       = tag_ff;
      scale_in     = scale_ff;
      mag_in       = mag_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      score_in     = score_ff;
      sat_in       = sat_ff;
      div_start    = 1'b0;
      div_item     = 1'b0;
      div_frac     = 1'b0;
      div_num      = err_sum_ff;
      div_den      = {{(64-CW){1'b0}}, item_cnt_ff};
      div_tag      = feacc_pkg::TAG_MEAN;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pred_in  = req_predicted;
               obs_in   = req_observed;
               last_in  = req_last;
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            if (ad > max_err_ff) begin
               max_err_in = ad;
            end
            if (item_cnt_ff != '0) begin
               naive_sum_in = naive_add[63:0];
               if (naive_add[64]) begin
                  ovf_in = 1'b1;
               end
            end
            prev_obs_in = obs_ff;
            if (item_cnt_ff < CNT_MAX) begin
               item_cnt_in = item_cnt_ff + CW'(1);
            end else begin
               ovf_in = 1'b1;
            end
            state_in = S_CHK;
            case (mode_ff)
               feacc_pkg::MODE_MAE,
               feacc_pkg::MODE_MASE: begin
                  acc_in   = {32'b0, ad};
                  state_in = S_ACC;
               end
               feacc_pkg::MODE_MSE,
               feacc_pkg::MODE_RMSE: begin
                  mul_in   = ad;
                  state_in = S_MUL;
               end
               feacc_pkg::MODE_RMSPE: begin
                  if (obs_ff != '0) begin
                     div_start = 1'b1;
                     div_item  = 1'b1;
                     div_num   = {32'b0, ad};
                     div_den   = {31'b0, a_mag};
                     div_tag   = feacc_pkg::TAG_RATIO;
                  end
               end
               feacc_pkg::MODE_SMAPE: begin
                  if (s_sum >= 33'd2) begin
                     div_start = 1'b1;
                     div_item  = 1'b1;
                     div_num   = {31'b0, ad, 1'b0};
                     div_den   = {31'b0, s_sum};
                     div_tag   = feacc_pkg::TAG_SMAPE;
                  end
               end
               default: begin
               end
            endcase
         end
         S_MUL: begin
            acc_in   = prod;
            state_in = S_ACC;
         end
         S_ACC: begin
            err_sum_in = err_add[63:0];
            if (err_add[64]) begin
               ovf_in = 1'b1;
            end
            state_in = S_CHK;
         end
         S_CHK: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else begin
               mag_in   = '0;
               state_in = S_OUT;
               case (mode_ff)
                  feacc_pkg::MODE_MAXAE: mag_in = {32'b0, max_err_ff};
                  feacc_pkg::MODE_MAE,
                  feacc_pkg::MODE_MSE,
                  feacc_pkg::MODE_RMSE,
                  feacc_pkg::MODE_SMAPE: div_start = 1'b1;
                  feacc_pkg::MODE_RMSPE: begin
                     if (used_cnt_ff != '0) begin
                        div_start = 1'b1;
                        div_den   = {{(64-CW){1'b0}}, used_cnt_ff};
                     end
                  end
                  feacc_pkg::MODE_MASE: begin
                     if (item_cnt_ff >= CW'(2)) begin
                        div_start = 1'b1;
                        div_num   = naive_sum_ff;
                        div_den   = {{(64-CW){1'b0}}, item_cnt_ff - CW'(1)};
                        div_tag   = feacc_pkg::TAG_SCALE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DIV: begin
            if (sub_ok) begin
               rem_in = sub_diff[63:0];
            end else begin
               rem_in = sub_a[63:0];
            end
            qd_in   = {qd_ff[DW-2:0], sub_ok};
            step_in = step_ff - KW'(1);
            if (step_ff == KW'(1)) begin
               state_in = S_DDONE;
            end
         end
         S_DDONE: begin
            if (q_over) begin
               ovf_in = 1'b1;
            end
            case (tag_ff)
               feacc_pkg::TAG_RATIO: begin
                  mul_in = q_cl[31:0];
                  if (used_cnt_ff < CNT_MAX) begin
                     used_cnt_in = used_cnt_ff + CW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
                  state_in = S_MUL;
               end
               feacc_pkg::TAG_SMAPE: begin
                  acc_in   = q_cl;
                  state_in = S_ACC;
               end
               feacc_pkg::TAG_SCALE: begin
                  scale_in  = (q_cl == '0) ? 64'd1 : q_cl;
                  div_start = 1'b1;
               end
               feacc_pkg::TAG_MASE: begin
                  mag_in   = q_cl;
                  state_in = S_OUT;
               end
               default: begin
                  // mean of the accumulated sum
                  mag_in   = q_cl;
                  state_in = S_OUT;
                  case (mode_ff)
                     feacc_pkg::MODE_MSE: mag_in = q_cl >> FRAC_BITS;
                     feacc_pkg::MODE_RMSE,
                     feacc_pkg::MODE_RMSPE: begin
                        rem_in    = q_cl;
                        qd_in     = '0;
                        sq_bit_in = 64'h4000_0000_0000_0000;
                        step_in   = SQRT_STEPS;
                        state_in  = S_SQRT;
                     end
                     feacc_pkg::MODE_MASE: begin
                        div_start = 1'b1;
                        div_frac  = 1'b1;
                        div_num   = q_cl;
                        div_den   = scale_ff;
                        div_tag   = feacc_pkg::TAG_MASE;
                     end
                     default: begin
                     end
                  endcase
               end
            endcase
         end
         S_SQRT: begin
            if (sub_ok) begin
               rem_in = sub_diff[63:0];
            end
            qd_in     = sq_res_next;
            sq_bit_in = sq_bit_ff >> 2;
            step_in   = step_ff - KW'(1);
            if (step_ff == KW'(1)) begin
               mag_in   = sq_res_next[63:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (mag_ff > feacc_pkg::SCORE_MAG_MAX) begin
                  score_in = 48'(-feacc_pkg::SCORE_MAG_MAX);
                  sat_in   = 1'b1;
               end else begin
                  score_in = 48'(-mag_ff);
                  sat_in   = ovf_ff;
               end
               err_sum_in   = '0;
               naive_sum_in = '0;
               max_err_in   = '0;
               item_cnt_in  = '0;
               used_cnt_in  = '0;
               prev_obs_in  = '0;
               ovf_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (div_start) begin
         rem_in   = '0;
         den_in   = div_den;
         tag_in   = div_tag;
         state_in = S_DIV;
         if (div_item) begin
            // small dividend: skip the leading zero bits
            qd_in   = {div_num[feacc_pkg::ITEM_NUM_W-1:0],
                       {(DW-feacc_pkg::ITEM_NUM_W){1'b0}}};
            step_in = ITEM_STEPS;
         end else if (div_frac) begin
            qd_in   = {div_num, {FRAC_BITS{1'b0}}};
            step_in = DIV_STEPS;
         end else begin
            qd_in   = {{FRAC_BITS{1'b0}}, div_num};
            step_in = DIV_STEPS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= feacc_pkg::MODE_MAXAE;
         err_sum_ff   <= '0;
         naive_sum_ff <= '0;
         max_err_ff   <= '0;
         item_cnt_ff  <= '0;
         used_cnt_ff  <= '0;
         prev_obs_ff  <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         err_sum_ff   <= err_sum_in;
         naive_sum_ff <= naive_sum_in;
         max_err_ff   <= max_err_in;
         item_cnt_ff  <= item_cnt_in;
         used_cnt_ff  <= used_cnt_in;
         prev_obs_ff  <= prev_obs_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pred_ff   <= pred_in;
      obs_ff    <= obs_in;
      last_ff   <= last_in;
      acc_ff    <= acc_in;
      mul_ff    <= mul_in;
      rem_ff    <= rem_in;
      qd_ff     <= qd_in;
      den_ff    <= den_in;
      sq_bit_ff <= sq_bit_in;
      step_ff   <= step_in;
      tag_ff    <= tag_in;
      scale_ff  <= scale_in;
      mag_ff    <= mag_in;
      score_ff  <= score_in;
      sat_ff    <= sat_in;
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_score     = score_ff;
   assign rsp_saturated = sat_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_OUT)
      else $error("result raised outside the output step");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous one still in work");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      item_cnt_ff <= CNT_MAX && used_cnt_ff <= item_cnt_ff)
      else $error("series counters out of range");

   a_score_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_score == '0 || rsp_score[feacc_pkg::SCORE_W-1]))
      else $error("score not negated");

endmodule
